[rtl/sckm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sckm_pkg
// Types, keyword table and helper functions shared by the keyword matcher.
// ---------------------------------------------------------------------------
package sckm_pkg;

	localparam int unsigned TABLE_SIZE   = 7;
	localparam int unsigned TEXT_BYTES   = 12;
	// length values (table lengths, keyword position) are compared at this width
	localparam int unsigned LEN_W        = 5;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned QPTR_W       = 1;
	localparam int unsigned QCNT_W       = 2;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] CASE_GAP   = 8'h20;

	// keyword text, right aligned, first character in the highest used byte
	localparam logic [8*TEXT_BYTES-1:0] KW_TEXT [TABLE_SIZE] = '{
		96'("LCD"),
		96'("LEDON"),
		96'("LEDOFF"),
		96'("Servo"),
		96'({"MOTOR_", "ON_CW"}),
		96'({"MOTOR_", "OFF"}),
		96'({"MOTOR_", "ON_CCW"})
	};

	localparam logic [LEN_W-1:0] KW_LEN [TABLE_SIZE] = '{
		5'd3, 5'd5, 5'd6, 5'd5, 5'd11, 5'd9, 5'd12
	};

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       line_end;
	} sckm_in_t;

	typedef struct packed {
		logic        matched;
		logic [2:0]  command_index;
		logic [15:0] argument;
	} sckm_out_t;

	// classified byte as queued between front and back
	typedef struct packed {
		logic [7:0]  rx_byte;
		logic        line_end;
		logic        is_space;
		logic [15:0] addend;
	} sckm_op_t;

	function automatic logic [7:0] kw_char(input int unsigned k, input logic [LEN_W-1:0] p);
		int   sh;
		logic [7:0] ch;
		begin
			ch = 8'h00;
			sh = 0;
			if (p < KW_LEN[k]) begin
				sh = 8 * (int'(KW_LEN[k]) - 1 - int'(p));
				ch = KW_TEXT[k][sh +: 8];
			end
			return ch;
		end
	endfunction

	// equal, or one is the other plus the case gap (no wrap)
	function automatic logic bytes_match(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] a9;
		logic [8:0] b9;
		begin
			a9 = {1'b0, a};
			b9 = {1'b0, b};
			return (a9 == b9) || (a9 == b9 + {1'b0, CASE_GAP}) ||
				(b9 == a9 + {1'b0, CASE_GAP});
		end
	endfunction

endpackage
`default_nettype wire

[rtl/sckm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sckm_front
// Accepts received bytes, classifies them and holds them in a short queue.
// ---------------------------------------------------------------------------
module sckm_front
	import sckm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire sckm_in_t in_item,
	output logic          op_valid,
	input  wire logic     op_ready,
	output sckm_op_t      op
);

	sckm_op_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_q;
	logic [QPTR_W-1:0]     rd_q;
	logic [QCNT_W-1:0]     cnt_q;
	sckm_op_t              new_op;
	logic                  push;
	logic                  pop;

	assign in_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op       = entries_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = op_valid && op_ready;

	always_comb begin
		new_op.rx_byte  = in_item.rx_byte;
		new_op.line_end = in_item.line_end;
		new_op.is_space = (in_item.rx_byte == SPACE_CHAR);
		// digit value modulo 2^16, byte minus '0'
		new_op.addend   = {8'h00, in_item.rx_byte} - {8'h00, DIGIT_ZERO};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/sckm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sckm_back
// Runs the keyword match and argument accumulation, registers the line result.
// ---------------------------------------------------------------------------
module sckm_back
	import sckm_pkg::*;
#(
	parameter int unsigned NUM_KEYWORDS    = 7,
	parameter int unsigned MAX_KEYWORD_LEN = 12
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     op_valid,
	output logic          op_ready,
	input  wire sckm_op_t op,
	output logic          out_valid,
	input  wire logic     out_ready,
	output sckm_out_t     out_item
);

	localparam int unsigned PW = $clog2(MAX_KEYWORD_LEN + 2);

	logic [NUM_KEYWORDS-1:0] alive_q;
	logic [PW-1:0]           pos_q;
	logic [7:0]              held_q;
	logic                    held_valid_q;
	logic                    after_space_q;
	logic [15:0]             acc_q;
	logic                    out_valid_q;
	sckm_out_t               out_item_q;

	logic [NUM_KEYWORDS-1:0] alive_c;
	logic [PW-1:0]           pos_c;
	logic [7:0]              held_c;
	logic                    held_valid_c;
	logic                    after_space_c;
	logic [15:0]             acc_c;
	logic                    hit;
	logic [2:0]              idx;
	logic                    fire;

	// a line end needs the output register free or draining this cycle
	assign op_ready  = !out_valid_q || out_ready || !op.line_end;
	assign fire      = op_valid && op_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		alive_c       = alive_q;
		pos_c         = pos_q;
		held_c        = held_q;
		held_valid_c  = held_valid_q;
		after_space_c = after_space_q;
		acc_c         = acc_q;
		if (after_space_q) begin
			// acc * 10 + digit, wraps at 16 bits
			acc_c = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + op.addend;
		end else begin
			if (held_valid_q) begin
				for (int unsigned k = 0; k < NUM_KEYWORDS; k++) begin
					if (!(LEN_W'(pos_q) < KW_LEN[k] &&
						bytes_match(held_q, kw_char(k, LEN_W'(pos_q))))) begin
						alive_c[k] = 1'b0;
					end
				end
				if (pos_q <= PW'(MAX_KEYWORD_LEN)) begin
					pos_c = pos_q + 1'b1;
				end
			end
			held_valid_c = 1'b0;
			if (!op.is_space) begin
				held_c       = op.rx_byte;
				held_valid_c = 1'b1;
			end
		end
		if (op.is_space) begin
			after_space_c = 1'b1;
			acc_c         = '0;
		end

		// highest matching index wins
		hit = 1'b0;
		idx = '0;
		for (int unsigned k = 0; k < NUM_KEYWORDS; k++) begin
			if (alive_c[k] && KW_LEN[k] == LEN_W'(pos_c) && pos_c != '0) begin
				hit = 1'b1;
				idx = 3'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q       <= '1;
			pos_q         <= '0;
			held_q        <= '0;
			held_valid_q  <= 1'b0;
			after_space_q <= 1'b0;
			acc_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fire) begin
				acc_q <= acc_c;
				if (op.line_end) begin
					alive_q       <= '1;
					pos_q         <= '0;
					held_q        <= '0;
					held_valid_q  <= 1'b0;
					after_space_q <= 1'b0;
				end else begin
					alive_q       <= alive_c;
					pos_q         <= pos_c;
					held_q        <= held_c;
					held_valid_q  <= held_valid_c;
					after_space_q <= after_space_c;
				end
			end
			if (fire && op.line_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && op.line_end) begin
			out_item_q.matched       <= hit;
			out_item_q.command_index <= hit ? idx : 3'd0;
			out_item_q.argument      <= acc_c;
		end
	end

endmodule
`default_nettype wire

[rtl/serial_command_keyword_matcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// serial_command_keyword_matcher
// Matches the keyword of a received text line and collects its argument.
// ---------------------------------------------------------------------------
// Takes one byte per cycle while the two-entry front queue has room, and
// the back consumes one queued byte per cycle unless a line end stalls,
// updating the keyword match flags and the multiply-by-ten argument in a
// single step. A line's result is registered in the output register when
// the back takes its line end. The next line's bytes keep flowing while a
// result waits to be taken; only a second line end stalls behind that result.
module serial_command_keyword_matcher
	import sckm_pkg::*;
#(
	parameter int unsigned NUM_KEYWORDS    = 7,
	parameter int unsigned MAX_KEYWORD_LEN = 12
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire sckm_in_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output sckm_out_t      out_item
);

	logic     op_valid;
	logic     op_ready;
	sckm_op_t op;

	sckm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	sckm_back #(
		.NUM_KEYWORDS    (NUM_KEYWORDS),
		.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire
